// File: sv/tesl_pkg.sv
// shared types and constants of the trapezoid envelope slew limiter
`default_nettype none
package tesl_pkg;

    localparam int IdxW  = 3;
    localparam int CfgW  = 20;
    localparam int LvlW  = 16;
    localparam int TimeW = 16;
    localparam int DurW  = 17;
    localparam int RateW = 20;
    localparam int ProdW = RateW + DurW;
    localparam int StepW = RateW + TimeW - 10;
    localparam int DivDendW = 32;
    localparam int DivSteps = 16;
    localparam int DivCntW  = $clog2(DivSteps);
    localparam int SDataW   = 88;
    localparam int MDataW   = 40;

    localparam logic [LvlW-1:0] LevelOne   = 16'd32768;
    localparam logic [LvlW-1:0] VisibleMin = 16'd33;
    localparam logic [DurW-1:0] ExtraTime  = 17'd102;

    // register indexes
    localparam logic [IdxW-1:0] RegIdleLevel   = 3'd0;
    localparam logic [IdxW-1:0] RegPeakLevel   = 3'd1;
    localparam logic [IdxW-1:0] RegRiseRate    = 3'd2;
    localparam logic [IdxW-1:0] RegFallRate    = 3'd3;
    localparam logic [IdxW-1:0] RegFallbackDur = 3'd4;
    localparam logic [IdxW-1:0] RegPeakTime    = 3'd5;
    localparam logic [IdxW-1:0] RegModeFlags   = 3'd6;

    // mode flag bits
    localparam int ModePlateau  = 0;
    localparam int ModeHoldPeak = 1;
    localparam int ModeSlotPeak = 2;
    localparam int ModeBoost    = 3;

    typedef struct packed {
        logic [TimeW-1:0] frame_time;
        logic             boost_on;
        logic [TimeW-1:0] slot_end;
        logic [TimeW-1:0] slot_start;
        logic             has_window;
        logic [TimeW-1:0] clip_duration;
        logic [TimeW-1:0] clip_time;
        logic             in_clip;
        logic             halted;
    } item_t;

    typedef struct packed {
        logic [LvlW-1:0]  idle_level;
        logic [LvlW-1:0]  peak_level;
        logic [TimeW-1:0] fallback_duration;
        logic [DurW-1:0]  peak_time;
        logic [3:0]       mode_flags;
    } env_cfg_t;

    // segment chosen for one item: a constant level or an interpolation
    typedef struct packed {
        logic            direct;
        logic [LvlW-1:0] direct_level;
        logic [LvlW-1:0] from;
        logic            desc;
        logic [LvlW-1:0] diff;
        logic [DurW-1:0] num;
        logic [DurW-1:0] den;
    } seg_t;

endpackage
`default_nettype wire

// File: sv/tesl_div.sv
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module tesl_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [tesl_pkg::DivDendW-1:0]     dividend,
    input  wire logic [tesl_pkg::DurW-1:0]         divisor,
    output logic                                   done,
    output logic [tesl_pkg::DivSteps-1:0]          quotient
);

    logic [tesl_pkg::DurW-1:0]     rem_reg;
    logic [tesl_pkg::DivSteps-1:0] low_reg;
    logic [tesl_pkg::DurW-1:0]     den_reg;
    logic [tesl_pkg::DivCntW-1:0]  cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [tesl_pkg::DurW:0] trial;
    logic [tesl_pkg::DurW:0] trial_sub;
    logic                    ge;

    always_comb begin
        trial     = {rem_reg, low_reg[tesl_pkg::DivSteps-1]};
        ge        = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
    end

    // quotient is known to fit in DivSteps bits, so the high half starts below the divisor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= {1'b0, dividend[tesl_pkg::DivDendW-1:tesl_pkg::DivSteps]};
                low_reg  <= dividend[tesl_pkg::DivSteps-1:0];
                den_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? trial_sub[tesl_pkg::DurW-1:0] : trial[tesl_pkg::DurW-1:0];
                low_reg <= {low_reg[tesl_pkg::DivSteps-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tesl_pkg::DivCntW'(tesl_pkg::DivSteps - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule
`default_nettype wire

// File: sv/tesl_seg.sv
// envelope segment selection: picks a constant level or an interpolation span
`default_nettype none
module tesl_seg (
    input  wire tesl_pkg::item_t    item,
    input  wire tesl_pkg::env_cfg_t cfg,
    output tesl_pkg::seg_t          seg
);

    function automatic logic [tesl_pkg::DurW-1:0] umin(
        input logic [tesl_pkg::DurW-1:0] a,
        input logic [tesl_pkg::DurW-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic [tesl_pkg::DurW-1:0] umax(
        input logic [tesl_pkg::DurW-1:0] a,
        input logic [tesl_pkg::DurW-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic [tesl_pkg::DurW-1:0] atleast1(input logic [tesl_pkg::DurW-1:0] a);
        return (a == '0) ? tesl_pkg::DurW'(1) : a;
    endfunction

    logic [tesl_pkg::LvlW-1:0] idle, peak;
    logic                      up_desc;
    logic [tesl_pkg::LvlW-1:0] up_diff;
    logic [tesl_pkg::DurW-1:0] ct, cd, ss, se, fb1;
    logic [tesl_pkg::DurW-1:0] p_dur, p_t, p_re, p_he;
    logic [tesl_pkg::DurW-1:0] tr_dur, tr_t, pk_raw, pk;
    logic                      use_slot;

    always_comb begin
        idle = (cfg.idle_level > tesl_pkg::LevelOne) ? tesl_pkg::LevelOne : cfg.idle_level;
        peak = (cfg.peak_level > tesl_pkg::LevelOne) ? tesl_pkg::LevelOne : cfg.peak_level;
        up_desc = peak < idle;
        up_diff = up_desc ? (idle - peak) : (peak - idle);

        ct  = {1'b0, item.clip_time};
        cd  = {1'b0, item.clip_duration};
        ss  = {1'b0, item.slot_start};
        se  = {1'b0, item.slot_end};
        fb1 = atleast1({1'b0, cfg.fallback_duration});

        // plateau shape
        p_dur = (cd == '0) ? umax(fb1, se + tesl_pkg::ExtraTime) : cd;
        p_t   = umin(ct, p_dur);
        p_re  = umin(ss, p_dur);
        p_he  = umin(umax(se, p_re), p_dur);

        // triangle shape
        if (cd != '0) begin
            tr_dur = cd;
        end else if (item.has_window) begin
            tr_dur = umax(fb1, ss + tesl_pkg::ExtraTime);
        end else begin
            tr_dur = fb1;
        end
        use_slot = cfg.mode_flags[tesl_pkg::ModeSlotPeak] && item.has_window && (ss != '0);
        if (use_slot) begin
            pk_raw = ss;
        end else if (cfg.peak_time[tesl_pkg::DurW-1]) begin
            pk_raw = tr_dur >> 1;
        end else begin
            pk_raw = {1'b0, cfg.peak_time[tesl_pkg::DurW-2:0]};
        end
        pk   = umin(pk_raw, tr_dur);
        tr_t = umin(ct, tr_dur);

        seg.direct       = 1'b1;
        seg.direct_level = idle;
        seg.from         = idle;
        seg.desc         = up_desc;
        seg.diff         = up_diff;
        seg.num          = '0;
        seg.den          = tesl_pkg::DurW'(1);

        priority if (item.halted) begin
            seg.direct_level = idle;
        end else if (!item.in_clip) begin
            seg.direct_level = (cfg.mode_flags[tesl_pkg::ModeBoost] && item.boost_on) ? peak : idle;
        end else if (cfg.mode_flags[tesl_pkg::ModePlateau] && item.has_window) begin
            if (p_t <= p_re) begin
                seg.direct = 1'b0;
                seg.num    = p_t;
                seg.den    = atleast1(p_re);
            end else if (p_t <= p_he) begin
                seg.direct_level = peak;
            end else begin
                seg.direct = 1'b0;
                seg.from   = peak;
                seg.desc   = !up_desc && (up_diff != '0);
                seg.num    = p_t - p_he;
                seg.den    = atleast1(p_dur - p_he);
            end
        end else if (cfg.mode_flags[tesl_pkg::ModeHoldPeak]) begin
            seg.direct_level = peak;
        end else begin
            seg.direct = 1'b0;
            if (tr_t <= pk) begin
                seg.num = tr_t;
                seg.den = atleast1(pk);
            end else begin
                seg.from = peak;
                seg.desc = !up_desc && (up_diff != '0);
                seg.num  = tr_t - pk;
                seg.den  = atleast1(tr_dur - pk);
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/trapezoid_envelope_slew_limiter.sv
// sequence: a constant target goes through ST_SEG, ST_SMUL and ST_SLEW; an interpolated
// target also passes ST_MUL, ST_DIVGO and ST_DIVW, where the 16-step serial divider runs
// throughput: one item at a time, accepted only in ST_IDLE; the next word is taken once
// the current result is registered, even while that result waits on m_tready
// reset: synchronous active low; registers return to defaults, level and valid clear
`default_nettype none
module trapezoid_envelope_slew_limiter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tesl_pkg::IdxW-1:0]     cfg_wr_index,
    input  wire logic [tesl_pkg::CfgW-1:0]     cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // halted, in_clip, clip_time, clip_duration, has_window, slot_start, slot_end,
    // boost_on, frame_time
    input  wire logic [tesl_pkg::SDataW-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // level, target_level, visible
    output logic [tesl_pkg::MDataW-1:0]        m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_MUL,
        ST_DIVGO,
        ST_DIVW,
        ST_SMUL,
        ST_SLEW
    } state_t;

    state_t state_reg;

    logic [tesl_pkg::LvlW-1:0]  idle_level_reg, peak_level_reg;
    logic [tesl_pkg::RateW-1:0] rise_rate_reg, fall_rate_reg;
    logic [tesl_pkg::TimeW-1:0] fallback_reg;
    logic [tesl_pkg::DurW-1:0]  peak_time_reg;
    logic [3:0]                 mode_flags_reg;

    tesl_pkg::item_t    item_reg;
    tesl_pkg::env_cfg_t cfg;
    tesl_pkg::seg_t     seg, seg_reg;

    logic [tesl_pkg::LvlW-1:0]  target_reg;
    logic [tesl_pkg::LvlW-1:0]  applied_reg;
    logic                       valid_reg;
    logic [tesl_pkg::ProdW-1:0] prod_reg;
    logic                       m_tvalid_reg;
    logic [tesl_pkg::MDataW-1:0] m_tdata_reg;

    logic                       div_done;
    logic [tesl_pkg::DivSteps-1:0] div_q;

    logic [tesl_pkg::RateW-1:0] mul_a;
    logic [tesl_pkg::DurW-1:0]  mul_b;

    logic                       rising, falling;
    logic [tesl_pkg::RateW-1:0] rate;
    logic [tesl_pkg::StepW-1:0] step;
    logic [tesl_pkg::StepW:0]   rise_sum;
    logic [tesl_pkg::LvlW-1:0]  rise_lvl, fall_lvl, gap, level_next;

    always_comb begin
        cfg.idle_level        = idle_level_reg;
        cfg.peak_level        = peak_level_reg;
        cfg.fallback_duration = fallback_reg;
        cfg.peak_time         = peak_time_reg;
        cfg.mode_flags        = mode_flags_reg;
    end

    tesl_seg u_seg (
        .item (item_reg),
        .cfg  (cfg),
        .seg  (seg)
    );

    tesl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIVGO),
        .dividend (prod_reg[tesl_pkg::DivDendW-1:0]),
        .divisor  (seg_reg.den),
        .done     (div_done),
        .quotient (div_q)
    );

    // slew decision against the registered target
    always_comb begin
        rising  = {1'b0, target_reg} > ({1'b0, applied_reg} + 17'd1);
        falling = ({1'b0, target_reg} + 17'd1) < {1'b0, applied_reg};
        if (rising) begin
            rate = rise_rate_reg;
        end else if (falling) begin
            rate = fall_rate_reg;
        end else begin
            rate = '0;
        end
        step     = prod_reg[tesl_pkg::ProdW-2:10];
        rise_sum = {{(tesl_pkg::StepW + 1 - tesl_pkg::LvlW){1'b0}}, applied_reg}
                 + {1'b0, step};
        rise_lvl = (rise_sum > {{(tesl_pkg::StepW + 1 - tesl_pkg::LvlW){1'b0}}, target_reg})
                 ? target_reg : rise_sum[tesl_pkg::LvlW-1:0];
        gap      = applied_reg - target_reg;
        fall_lvl = ({{(tesl_pkg::StepW - tesl_pkg::LvlW){1'b0}}, gap} <= step)
                 ? target_reg : (applied_reg - step[tesl_pkg::LvlW-1:0]);
        priority if (item_reg.halted) begin
            level_next = seg_reg.direct_level;
        end else if (!valid_reg || rate == '0) begin
            level_next = target_reg;
        end else if (rising) begin
            level_next = rise_lvl;
        end else begin
            level_next = fall_lvl;
        end
    end

    // shared multiplier operands: span product, then slew step
    always_comb begin
        if (state_reg == ST_SMUL) begin
            mul_a = rate;
            mul_b = {1'b0, item_reg.frame_time};
        end else begin
            mul_a = {{(tesl_pkg::RateW - tesl_pkg::LvlW){1'b0}}, seg_reg.diff};
            mul_b = seg_reg.num;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idle_level_reg <= '0;
            peak_level_reg <= tesl_pkg::LevelOne;
            rise_rate_reg  <= '0;
            fall_rate_reg  <= '0;
            fallback_reg   <= 16'd1024;
            peak_time_reg  <= '1;
            mode_flags_reg <= '0;
            applied_reg    <= '0;
            valid_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    tesl_pkg::RegIdleLevel:   idle_level_reg <= cfg_wr_data[tesl_pkg::LvlW-1:0];
                    tesl_pkg::RegPeakLevel:   peak_level_reg <= cfg_wr_data[tesl_pkg::LvlW-1:0];
                    tesl_pkg::RegRiseRate:    rise_rate_reg  <= cfg_wr_data;
                    tesl_pkg::RegFallRate:    fall_rate_reg  <= cfg_wr_data;
                    tesl_pkg::RegFallbackDur: fallback_reg   <= cfg_wr_data[tesl_pkg::TimeW-1:0];
                    tesl_pkg::RegPeakTime:    peak_time_reg  <= cfg_wr_data[tesl_pkg::DurW-1:0];
                    tesl_pkg::RegModeFlags:   mode_flags_reg <= cfg_wr_data[3:0];
                    default: ;
                endcase
            end

            // in ST_SLEW the new result takes over the output register
            if (m_tvalid_reg && m_tready && state_reg != ST_SLEW) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        item_reg  <= tesl_pkg::item_t'(s_tdata[$bits(tesl_pkg::item_t)-1:0]);
                        state_reg <= ST_SEG;
                    end
                end
                ST_SEG: begin
                    seg_reg    <= seg;
                    target_reg <= seg.direct_level;
                    state_reg  <= seg.direct ? ST_SMUL : ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_DIVGO;
                end
                ST_DIVGO: begin
                    state_reg <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (div_done) begin
                        target_reg <= seg_reg.desc ? (seg_reg.from - div_q)
                                                   : (seg_reg.from + div_q);
                        state_reg  <= ST_SMUL;
                    end
                end
                ST_SMUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_SLEW;
                end
                ST_SLEW: begin
                    // wait for the output register to free up
                    if (!m_tvalid_reg || m_tready) begin
                        applied_reg  <= level_next;
                        valid_reg    <= 1'b1;
                        m_tdata_reg  <= {7'd0, level_next > tesl_pkg::VisibleMin,
                                         target_reg, level_next};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
